### rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared codes, field widths and reset values for the status frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int unsigned TICK_W  = 20;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CFGI_W  = 2;
	localparam int unsigned M_DATA_W = 40;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

	localparam logic [TICK_W-1:0] TIMEOUT_RST = 20'd100000;
	localparam logic [BYTE_W-1:0] MAX_LEN_RST = 8'd250;
	localparam logic [BYTE_W-1:0] MAX_ID_RST  = 8'd253;
	localparam logic [BYTE_W-1:0] MIN_LEN     = 8'd2;

	localparam logic [CFGI_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFGI_W-1:0] REG_MAX_LEN = 2'd1;
	localparam logic [CFGI_W-1:0] REG_MAX_ID  = 2'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_END   = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_CORRUPT = 2'd1;
	localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd2;

	localparam logic [PHASE_W-1:0] PH_HUNT   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ID     = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LENGTH = 3'd2;
	localparam logic [PHASE_W-1:0] PH_ERROR  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_PARAM  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CHECK  = 3'd5;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] frame_id;
		logic [BYTE_W-1:0] error_byte;
		logic [BYTE_W-1:0] param_byte;
		logic [BYTE_W-1:0] param_index;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

### rtl/core/status_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// status_frame_receiver_core
// Path: an input transaction is registered in the input register, and the
// parse logic on it feeds the result register.
// Throughput: one item per cycle unless a held result waits on m_tready.
// Reset: arst_n clears state, counters, valid flags and restores the
// register defaults (timeout 100000, max length 250, max ID 253).
// ----------------------------------------------------------------------------
module status_frame_receiver_core
	import sfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [BYTE_W-1:0]   s_tdata,    // rx_byte
	input  logic                s_tuser,    // operation
	output logic                m_tvalid,
	input  logic                m_tready,
	// frame_id[7:0], error_byte[15:8], param_byte[23:16], param_index[31:24],
	// status[33:32], zero fill[39:34]
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser,    // kind
	input  logic                cfg_wen,
	input  logic [CFGI_W-1:0]   cfg_index,
	input  logic [TICK_W-1:0]   cfg_wdata
);

	logic [TICK_W-1:0] timeout_q;
	logic [BYTE_W-1:0] max_len_q;
	logic [BYTE_W-1:0] max_id_q;

	logic              valid_s1;
	logic              op_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [PHASE_W-1:0] phase_q;
	logic               prev_ff_q;
	logic [BYTE_W-1:0]  id_q;
	logic [BYTE_W-1:0]  len_q;
	logic [BYTE_W-1:0]  err_q;
	logic [BYTE_W-1:0]  cnt_q;
	logic [BYTE_W-1:0]  sum_q;
	logic [TICK_W-1:0]  tick_q;

	logic    out_valid_q;
	result_t out_q;

	logic advance;

	logic [PHASE_W-1:0] phase_d;
	logic               prev_ff_d;
	logic [BYTE_W-1:0]  id_d;
	logic [BYTE_W-1:0]  len_d;
	logic [BYTE_W-1:0]  err_d;
	logic [BYTE_W-1:0]  cnt_d;
	logic [BYTE_W-1:0]  sum_d;
	logic [TICK_W-1:0]  tick_d;
	logic               res_vld;
	result_t            res;

	logic [TICK_W-1:0]  tick_inc;
	logic [BYTE_W-1:0]  cnt_inc;
	logic [BYTE_W:0]    cnt_end;
	logic               is_ff;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			max_len_q <= MAX_LEN_RST;
			max_id_q  <= MAX_ID_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_wdata;
				REG_MAX_LEN: max_len_q <= cfg_wdata[BYTE_W-1:0];
				REG_MAX_ID:  max_id_q  <= cfg_wdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign tick_inc = tick_q + TICK_W'(1);
	assign cnt_inc  = cnt_q + BYTE_W'(1);
	assign cnt_end  = {1'b0, cnt_inc} + (BYTE_W+1)'(2);
	assign is_ff    = (byte_s1 == HDR_BYTE);

	always_comb begin
		phase_d   = phase_q;
		prev_ff_d = prev_ff_q;
		id_d      = id_q;
		len_d     = len_q;
		err_d     = err_q;
		cnt_d     = cnt_q;
		sum_d     = sum_q;
		tick_d    = tick_q;
		res_vld   = 1'b0;
		res       = '0;
		if (op_s1 == OP_TICK) begin
			if (timeout_q != '0) begin
				tick_d = tick_inc;
				if (tick_inc >= timeout_q) begin
					tick_d     = '0;
					phase_d    = PH_HUNT;
					prev_ff_d  = 1'b0;
					res_vld    = 1'b1;
					res.kind   = KIND_END;
					res.status = ST_TIMEOUT;
				end
			end
		end else begin
			unique case (phase_q)
				PH_ID: begin
					if (byte_s1 > max_id_q) begin
						phase_d   = is_ff ? PH_ID : PH_HUNT;
						prev_ff_d = 1'b0;
					end else begin
						id_d    = byte_s1;
						sum_d   = byte_s1;
						phase_d = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					if (byte_s1 > max_len_q || byte_s1 < MIN_LEN) begin
						if (id_q == HDR_BYTE) begin
							if (byte_s1 > max_id_q) begin
								phase_d   = is_ff ? PH_ID : PH_HUNT;
								prev_ff_d = 1'b0;
							end else begin
								id_d      = byte_s1;
								sum_d     = byte_s1;
								phase_d   = PH_LENGTH;
								prev_ff_d = 1'b0;
							end
						end else begin
							phase_d   = PH_HUNT;
							prev_ff_d = is_ff;
						end
					end else begin
						len_d   = byte_s1;
						sum_d   = sum_q + byte_s1;
						phase_d = PH_ERROR;
					end
				end
				PH_ERROR: begin
					err_d   = byte_s1;
					sum_d   = sum_q + byte_s1;
					cnt_d   = '0;
					phase_d = (len_q == MIN_LEN) ? PH_CHECK : PH_PARAM;
				end
				PH_PARAM: begin
					res_vld         = 1'b1;
					res.kind        = KIND_PARAM;
					res.frame_id    = id_q;
					res.error_byte  = err_q;
					res.param_byte  = byte_s1;
					res.param_index = cnt_q;
					res.status      = ST_OK;
					sum_d           = sum_q + byte_s1;
					cnt_d           = cnt_inc;
					if (cnt_end >= {1'b0, len_q}) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					res_vld        = 1'b1;
					res.kind       = KIND_END;
					res.frame_id   = id_q;
					res.error_byte = err_q;
					res.status     = (byte_s1 == ~sum_q) ? ST_OK : ST_CORRUPT;
					phase_d        = PH_HUNT;
					prev_ff_d      = 1'b0;
					tick_d         = '0;
				end
				default: begin
					if (prev_ff_q && is_ff) begin
						phase_d   = PH_ID;
						prev_ff_d = 1'b0;
					end else begin
						phase_d   = PH_HUNT;
						prev_ff_d = is_ff;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			prev_ff_q <= 1'b0;
			id_q      <= '0;
			len_q     <= '0;
			err_q     <= '0;
			cnt_q     <= '0;
			sum_q     <= '0;
			tick_q    <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			prev_ff_q <= prev_ff_d;
			id_q      <= id_d;
			len_q     <= len_d;
			err_q     <= err_d;
			cnt_q     <= cnt_d;
			sum_q     <= sum_d;
			tick_q    <= tick_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_vld;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_vld) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {6'd0, out_q.status, out_q.param_index, out_q.param_byte,
		out_q.error_byte, out_q.frame_id};

endmodule

### tb/tb_status_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_status_frame_receiver_core
// Streams received bytes and time ticks into the status frame receiver and
// checks every parameter, frame end and timeout transaction against an
// in-bench parser that tracks header hunting, ID/length screening with
// rescan, checksum and tick timeout. Directed frames come first, then random
// well-formed frames mixed with noise, broken frames and ticks under several
// register settings, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_status_frame_receiver_core;
	import sfr_pkg::*;

	localparam logic [CFGI_W-1:0] REG_NONE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 4;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;
	logic                cfg_wen;
	logic [CFGI_W-1:0]   cfg_index;
	logic [TICK_W-1:0]   cfg_wdata;

	// parser image
	logic [PHASE_W-1:0] ph;
	logic               prev_ff;
	logic [BYTE_W-1:0]  hid, hlen, herr, bcnt, sacc;
	logic [TICK_W-1:0]  tcnt;
	logic [TICK_W-1:0]  lim_ticks;
	logic [BYTE_W-1:0]  lim_len, lim_id;

	result_t     due[$];
	int          fails;
	int unsigned sent_items;
	int unsigned cycles;
	int unsigned sink_hold;
	bit          src_pace;
	bit          snk_pace;

	status_frame_receiver_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void hunt_byte(input logic [BYTE_W-1:0] b);
		if (prev_ff && b == HDR_BYTE) begin
			ph = PH_ID;
			prev_ff = 1'b0;
		end else begin
			ph = PH_HUNT;
			prev_ff = (b == HDR_BYTE);
		end
	endfunction

	function automatic void take_id(input logic [BYTE_W-1:0] b);
		if (b > lim_id) begin
			prev_ff = 1'b1;
			hunt_byte(b);
		end else begin
			hid = b;
			sacc = b;
			ph = PH_LENGTH;
		end
	endfunction

	function automatic void rescan(input logic [BYTE_W-1:0] b);
		if (ph == PH_ID)
			take_id(b);
		else
			hunt_byte(b);
	endfunction

	function automatic void parse_step(input logic op, input logic [BYTE_W-1:0] b);
		result_t r;
		r = '0;
		if (op == OP_TICK) begin
			if (lim_ticks != '0) begin
				tcnt = tcnt + 1'b1;
				if (tcnt >= lim_ticks) begin
					tcnt = '0;
					ph = PH_HUNT;
					prev_ff = 1'b0;
					r.kind = KIND_END;
					r.status = ST_TIMEOUT;
					due = {due, r};
				end
			end
		end else begin
			case (ph)
				PH_ID: take_id(b);
				PH_LENGTH: begin
					if (b > lim_len || b < MIN_LEN) begin
						ph = PH_HUNT;
						prev_ff = 1'b0;
						rescan(HDR_BYTE);
						rescan(hid);
						rescan(b);
					end else begin
						hlen = b;
						sacc = sacc + b;
						ph = PH_ERROR;
					end
				end
				PH_ERROR: begin
					herr = b;
					sacc = sacc + b;
					bcnt = '0;
					ph = (hlen == MIN_LEN) ? PH_CHECK : PH_PARAM;
				end
				PH_PARAM: begin
					r.kind = KIND_PARAM;
					r.frame_id = hid;
					r.error_byte = herr;
					r.param_byte = b;
					r.param_index = bcnt;
					due = {due, r};
					sacc = sacc + b;
					bcnt = bcnt + 1'b1;
					if ({1'b0, bcnt} + 9'd2 >= {1'b0, hlen})
						ph = PH_CHECK;
				end
				PH_CHECK: begin
					r.kind = KIND_END;
					r.frame_id = hid;
					r.error_byte = herr;
					r.status = (b == ~sacc) ? ST_OK : ST_CORRUPT;
					due = {due, r};
					ph = PH_HUNT;
					prev_ff = 1'b0;
					tcnt = '0;
				end
				default: hunt_byte(b);
			endcase
		end
	endfunction

	function automatic void cmp_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin : chk_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due.size() == 0) begin
				$display("%0t unexpected result: expected none, actual tuser %0h tdata %0h",
					$time, m_tuser, m_tdata);
				fails++;
			end else begin
				want = due.pop_front();
				cmp_field("kind", want.kind, m_tuser);
				cmp_field("frame_id", want.frame_id, m_tdata[7:0]);
				cmp_field("error_byte", want.error_byte, m_tdata[15:8]);
				cmp_field("param_byte", want.param_byte, m_tdata[23:16]);
				cmp_field("param_index", want.param_index, m_tdata[31:24]);
				cmp_field("status", want.status, m_tdata[33:32]);
				cmp_field("zero fill", 0, m_tdata[39:34]);
			end
		end
	end

	// sink stall drawn per result
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sink_hold = snk_pace ? $urandom_range(0, 13) : 0;
			if (sink_hold != 0)
				m_tready <= 1'b0;
		end else if (sink_hold != 0) begin
			sink_hold--;
			if (sink_hold == 0)
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, due.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
		int unsigned gap;
		gap = src_pace ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		parse_step(op, b);
		sent_items++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [TICK_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_TIMEOUT: lim_ticks = val;
			REG_MAX_LEN: lim_len = val[BYTE_W-1:0];
			REG_MAX_ID:  lim_id = val[BYTE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic send_bytes(input logic [BYTE_W-1:0] seq[$]);
		foreach (seq[i])
			send_item(OP_BYTE, seq[i]);
	endtask

	// cut > 0 truncates the frame to that many bytes
	task automatic send_frame(input logic [BYTE_W-1:0] fid, input logic [BYTE_W-1:0] flen,
		input bit bad_sum, input int cut, input int tick_pct);
		logic [BYTE_W-1:0] seq[$];
		logic [BYTE_W-1:0] sum, err, p;
		err = $urandom;
		seq = {HDR_BYTE, HDR_BYTE, fid, flen, err};
		sum = fid + flen + err;
		for (int i = 0; i < int'(flen) - 2; i++) begin
			p = $urandom;
			seq = {seq, p};
			sum = sum + p;
		end
		p = bad_sum ? ~sum ^ 8'($urandom_range(1, 255)) : ~sum;
		seq = {seq, p};
		if (cut > 0 && cut < seq.size())
			seq = seq[0:cut-1];
		foreach (seq[i]) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_item(OP_TICK, $urandom);
			send_item(OP_BYTE, seq[i]);
		end
	endtask

	function automatic logic [BYTE_W-1:0] ok_len();
		if (lim_len < MIN_LEN)
			return $urandom_range(2, 255);
		if ($urandom_range(0, 49) == 0)
			return $urandom_range(2, lim_len);
		return $urandom_range(2, (lim_len < 12) ? lim_len : 12);
	endfunction

	task automatic run_traffic(input int unsigned n, input int tick_pct);
		int unsigned stop;
		int unsigned r;
		int unsigned k;
		logic [BYTE_W-1:0] fid, flen;
		stop = sent_items + n;
		while (sent_items < stop) begin
			if ($urandom_range(0, 24) == 0)
				src_pace = !src_pace;
			if ($urandom_range(0, 24) == 0)
				snk_pace = !snk_pace;
			r = $urandom_range(0, 99);
			fid = $urandom_range(0, lim_id);
			flen = ok_len();
			if (r < 65) begin
				if ($urandom_range(0, 9) == 0)
					send_item(OP_BYTE, HDR_BYTE);
				send_frame(fid, flen, $urandom_range(0, 4) == 0, 0, tick_pct);
			end else if (r < 72) begin
				if (lim_id < 8'd255)
					fid = $urandom_range(int'(lim_id) + 1, 255);
				send_frame(fid, flen, 1'b0, 0, tick_pct);
			end else if (r < 80) begin
				if (lim_len < 8'd255 && $urandom_range(0, 1) == 1)
					flen = $urandom_range(int'(lim_len) + 1, 255);
				else
					flen = $urandom_range(0, 1);
				send_frame(fid, flen, 1'b0, 5 + $urandom_range(0, 2), tick_pct);
			end else if (r < 88) begin
				send_frame(fid, flen, 1'b0, $urandom_range(1, 4 + int'(flen)), tick_pct);
			end else if (r < 95) begin
				k = $urandom_range(1, 6);
				repeat (k)
					send_item(OP_BYTE, ($urandom_range(0, 9) < 4) ? HDR_BYTE : 8'($urandom));
			end else begin
				k = $urandom_range(1, 4);
				repeat (k)
					send_item(OP_TICK, $urandom);
			end
		end
		settle();
	endtask

	task automatic test_directed_frames();
		src_pace = 1'b0;
		snk_pace = 1'b0;
		// shortest good frame, no parameters
		send_bytes({8'hFF, 8'hFF, 8'h01, 8'h02, 8'h00, 8'hFC});
		// corrupt checksum with extreme parameter bytes
		send_bytes({8'hFF, 8'hFF, 8'h05, 8'h04, 8'h80, 8'h00, 8'hFF, 8'h76});
		// bad ID: the third header byte is rescanned into a good frame
		send_bytes({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'hFE});
		// length below the minimum, then above the maximum
		send_bytes({8'hFF, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'hFB});
		settle();
	endtask

	task automatic test_tick_limits();
		write_reg(REG_TIMEOUT, 20'd1);
		send_item(OP_TICK, 8'h00);
		settle();
		write_reg(REG_TIMEOUT, 20'd0);
		write_reg(REG_NONE, 20'd3);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_TICK, 8'h5A);
		settle();
		write_reg(REG_TIMEOUT, 20'd2);
		send_bytes({8'hFF, 8'hFF, 8'h01});
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		settle();
	endtask

	task automatic test_longest_frame();
		src_pace = 1'b1;
		snk_pace = 1'b1;
		send_frame(8'h00, 8'd255, 1'b0, 0, 0);
		settle();
	endtask

	task automatic test_default_regs();
		write_reg(REG_TIMEOUT, TIMEOUT_RST);
		write_reg(REG_MAX_LEN, MAX_LEN_RST);
		write_reg(REG_MAX_ID, MAX_ID_RST);
		run_traffic(150, 2);
	endtask

	task automatic test_wide_limits();
		write_reg(REG_MAX_ID, 20'hF3A00);
		write_reg(REG_MAX_LEN, 20'h0A1FF);
		write_reg(REG_TIMEOUT, 20'hFFFFF);
		test_longest_frame();
		run_traffic(250, 3);
	endtask

	task automatic test_tight_limits();
		write_reg(REG_MAX_ID, 20'd255);
		write_reg(REG_MAX_LEN, 20'd2);
		write_reg(REG_TIMEOUT, 20'd7);
		run_traffic(250, 10);
	endtask

	task automatic test_all_lengths_rejected();
		write_reg(REG_MAX_LEN, 20'd1);
		write_reg(REG_TIMEOUT, 20'd3);
		run_traffic(120, 15);
		write_reg(REG_MAX_LEN, 20'd0);
		run_traffic(100, 15);
	endtask

	task automatic test_no_timeout();
		write_reg(REG_MAX_ID, 20'd100);
		write_reg(REG_MAX_LEN, 20'd20);
		write_reg(REG_TIMEOUT, 20'd0);
		run_traffic(300, 5);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_BYTE;
		m_tready <= 1'b1;
		cfg_wen <= 1'b0;
		cfg_index <= REG_TIMEOUT;
		cfg_wdata <= '0;
		fails = 0;
		sent_items = 0;
		cycles = 0;
		sink_hold = 0;
		src_pace = 1'b0;
		snk_pace = 1'b0;
		ph = PH_HUNT;
		prev_ff = 1'b0;
		hid = '0;
		hlen = '0;
		herr = '0;
		bcnt = '0;
		sacc = '0;
		tcnt = '0;
		lim_ticks = TIMEOUT_RST;
		lim_len = MAX_LEN_RST;
		lim_id = MAX_ID_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_tick_limits();
		test_default_regs();
		test_wide_limits();
		test_tight_limits();
		test_all_lengths_rejected();
		test_no_timeout();
		test_default_regs();

		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
